// File: rtl/mhpq_pkg.sv
package mhpq_pkg;

  localparam int DEF_CAPACITY = 255;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic signed [31:0] new_key;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic [7:0]         position;
    logic [1:0]         status;
    logic [7:0]         entry_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_UP_RD,
    S_UP_CHK,
    S_DN_RD,
    S_DN_RD2,
    S_DN_CHK,
    S_WRITE,
    S_RM_RD,
    S_RM_LAST,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the request
    logic rd_pos;     // read mem[pos]
    logic rd_parent;  // read mem[pos/2]
    logic rd_child;   // read mem[child]
    logic rd_child2;  // read mem[child+1]
    logic rd_last;    // read mem[fill]
    logic rd_root;    // read root into result key
    logic up_move;    // parent moves down, pos climbs
    logic dn_move;    // child moves up, pos descends
    logic wr_final;   // write held key at pos
    logic srch_init;  // start search at root
    logic srch_step;  // advance search
    logic ins_start;  // fill++, pos = fill, k = key
    logic rm_start;   // fill--, pos=1, k = last
    logic mod_setup;  // k = new key at found pos
    logic done;       // present result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_is_root;
    logic up_go;      // k > parent
    logic has_child;
    logic has_child2;
    logic dn_go;      // k < larger child
    logic srch_end;   // search stack exhausted
    logic found;
    logic fill_nonzero;
    logic new_gt;
    logic new_lt;
  } stat_t;

endpackage

// File: rtl/mhpq_ctrl.sv
module mhpq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      action,
  input  mhpq_pkg::stat_t st,
  output mhpq_pkg::cmd_t  cmd,
  output logic            busy
);
  import mhpq_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0] act_r, act_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= ACT_INSERT;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          act_nxt   = action;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (act_r)
          ACT_INSERT: begin
            if (st.full) state_nxt = S_DONE;
            else begin
              cmd.ins_start = 1'b1;
              state_nxt = S_UP_RD;
            end
          end
          ACT_REMOVE: begin
            if (st.empty) state_nxt = S_DONE;
            else begin
              cmd.rd_root = 1'b1;
              state_nxt = S_RM_RD;
            end
          end
          default: begin
            cmd.srch_init = 1'b1;
            state_nxt = S_SRCH_RD;
          end
        endcase
      end
      S_RM_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt = S_RM_LAST;
      end
      S_RM_LAST: begin
        cmd.rm_start = 1'b1;
        state_nxt = st.fill_nonzero ? S_DN_RD : S_DONE;
      end
      S_SRCH_RD: begin
        if (st.srch_end) state_nxt = S_DONE;
        else begin
          cmd.rd_pos = 1'b1;
          state_nxt = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        cmd.srch_step = 1'b1;
        state_nxt = S_SRCH_RD;
      end
      S_UP_RD: begin
        if (st.pos_is_root) state_nxt = S_WRITE;
        else begin
          cmd.rd_parent = 1'b1;
          state_nxt = S_UP_CHK;
        end
      end
      S_UP_CHK: begin
        if (st.up_go) begin
          cmd.up_move = 1'b1;
          state_nxt = S_UP_RD;
        end else state_nxt = S_WRITE;
      end
      S_DN_RD: begin
        if (!st.has_child) state_nxt = S_WRITE;
        else begin
          cmd.rd_child = 1'b1;
          state_nxt = S_DN_RD2;
        end
      end
      S_DN_RD2: begin
        cmd.rd_child2 = st.has_child2;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (st.dn_go) begin
          cmd.dn_move = 1'b1;
          state_nxt = S_DN_RD;
        end else state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr_final = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // modify path after the search completes
        if (act_r == ACT_MODIFY && st.found && (st.new_gt || st.new_lt)) begin
          cmd.mod_setup = 1'b1;
          act_nxt = ACT_FIND;
          state_nxt = st.new_gt ? S_UP_RD : S_DN_RD;
        end else begin
          cmd.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/mhpq_dp.sv
module mhpq_dp #(
  parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mhpq_pkg::in_item_t   in_item,
  input  mhpq_pkg::cmd_t       cmd,
  output mhpq_pkg::stat_t      st,
  output logic                 out_valid,
  output mhpq_pkg::out_item_t  out_item
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY + 1);
  localparam int PW = AW + 1;  // room for child index beyond capacity
  localparam int SW = $clog2(AW + 2);
  localparam logic [AW-1:0] CAP = AW'(CAPACITY);

  logic signed [31:0] mem [0:CAPACITY];

  logic [AW-1:0]      fill_r;
  logic [PW-1:0]      pos_r;
  logic signed [31:0] k_r;
  logic signed [31:0] key_r, nkey_r, okey_r;
  logic [1:0]         act_r;
  logic signed [31:0] rd_r;
  logic signed [31:0] c1_r;
  logic               c2v_r;
  logic [AW-1:0]      found_r;
  logic [AW-1:0]      best_r;
  // explicit search stack: pending right siblings
  logic [AW-1:0]      stk_r [0:AW];
  logic [SW-1:0]      sp_r;
  logic [PW-1:0]      cur_r;
  logic               cur_v_r;
  logic               outv_r;
  // remember whether a remove or insert really happened
  logic               rm_seen_r;
  logic               ins_seen_r;

  logic [PW-1:0] child_w;
  assign child_w = {pos_r[PW-2:0], 1'b0};

  // larger of the two children
  logic signed [31:0] bigc;
  assign bigc = (c2v_r && c1_r < rd_r) ? rd_r : c1_r;

  // memory reads and writes
  always_ff @(posedge clk) begin
    if (cmd.rd_pos)    rd_r <= mem[cur_r[AW-1:0]];
    if (cmd.rd_parent) rd_r <= mem[pos_r[AW:1]];
    if (cmd.rd_child)  c1_r <= mem[child_w[AW-1:0]];
    if (cmd.rd_child2) rd_r <= mem[child_w[AW-1:0] | AW'(1)];
    if (cmd.rd_last)   rd_r <= mem[fill_r];
    if (cmd.rd_root)   rd_r <= mem[AW'(1)];
    if (cmd.up_move)   mem[pos_r[AW-1:0]] <= rd_r;
    if (cmd.dn_move)   mem[pos_r[AW-1:0]] <= bigc;
    if (cmd.wr_final)  mem[pos_r[AW-1:0]] <= k_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      outv_r  <= 1'b0;
      sp_r    <= '0;
      cur_v_r <= 1'b0;
    end else begin
      outv_r <= cmd.done;
      if (cmd.ins_start) fill_r <= fill_r + AW'(1);
      if (cmd.rm_start)  fill_r <= fill_r - AW'(1);
      if (cmd.srch_init) begin
        sp_r    <= '0;
        cur_v_r <= (fill_r != '0);
      end
      if (cmd.srch_step) begin
        // descend into left child if current node is not pruned
        if (rd_r != key_r && !(key_r > rd_r)
            && {cur_r[PW-2:0], 1'b0} <= PW'(fill_r)) begin
          cur_v_r <= 1'b1;
          if ({cur_r[PW-2:0], 1'b1} <= PW'(fill_r)) begin
            sp_r <= sp_r + SW'(1);
          end
        end else if (sp_r != '0) begin
          cur_v_r <= 1'b1;
          sp_r    <= sp_r - SW'(1);
        end else cur_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_item.action;
      key_r  <= in_item.key;
      nkey_r <= in_item.new_key;
      okey_r <= '0;
      best_r <= '0;
    end
    if (cmd.srch_init) cur_r <= PW'(1);
    if (cmd.srch_step) begin
      if (rd_r == key_r && cur_r[AW-1:0] > best_r) best_r <= cur_r[AW-1:0];
      if (rd_r != key_r && !(key_r > rd_r)
          && {cur_r[PW-2:0], 1'b0} <= PW'(fill_r)) begin
        cur_r <= {cur_r[PW-2:0], 1'b0};
        if ({cur_r[PW-2:0], 1'b1} <= PW'(fill_r))
          stk_r[sp_r] <= {cur_r[AW-2:0], 1'b1};
      end else if (sp_r != '0) begin
        cur_r <= PW'(stk_r[sp_r - SW'(1)]);
      end
    end
    if (cmd.ins_start) begin
      pos_r <= PW'(fill_r + AW'(1));
      k_r   <= key_r;
    end
    // root value read at dispatch is still in rd_r here
    if (cmd.rd_last) okey_r <= rd_r;
    if (cmd.rm_start) begin
      pos_r <= PW'(1);
      k_r   <= rd_r;
    end
    if (cmd.mod_setup) begin
      pos_r <= PW'(best_r);
      k_r   <= nkey_r;
    end
    if (cmd.up_move) pos_r <= {1'b0, pos_r[PW-1:1]};
    if (cmd.rd_child) c2v_r <= 1'b0;
    if (cmd.rd_child2) c2v_r <= 1'b1;
    if (cmd.dn_move) pos_r <= (c2v_r && c1_r < rd_r) ? (child_w | PW'(1)) : child_w;
    if (cmd.done) found_r <= best_r;
  end

  // per-item flags for the result status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rm_seen_r  <= 1'b0;
      ins_seen_r <= 1'b0;
    end
    if (cmd.rm_start)  rm_seen_r  <= 1'b1;
    if (cmd.ins_start) ins_seen_r <= 1'b1;
  end

  // status to controller
  always_comb begin
    st.full         = (fill_r >= CAP);
    st.empty        = (fill_r == '0);
    st.pos_is_root  = (pos_r <= PW'(1));
    st.up_go        = (k_r > rd_r);
    st.has_child    = (child_w <= PW'(fill_r));
    st.has_child2   = (child_w < PW'(fill_r));
    st.dn_go        = (k_r < bigc);
    st.srch_end     = !cur_v_r;
    st.found        = (best_r != '0);
    st.fill_nonzero = (fill_r != '0);
    st.new_gt       = (nkey_r > key_r);
    st.new_lt       = (nkey_r < key_r);
  end

  // result item
  logic [AW-1:0] rpos;
  assign rpos = (act_r == ACT_MODIFY || act_r == ACT_FIND) ? found_r : '0;

  assign out_valid = outv_r;
  always_comb begin
    out_item.out_key     = okey_r;
    out_item.position    = 8'(rpos);
    out_item.entry_count = 8'(fill_r);
    case (act_r)
      ACT_INSERT: out_item.status = ins_seen_r ? ST_OK : ST_FULL;
      ACT_REMOVE: out_item.status = rm_seen_r ? ST_OK : ST_EMPTY;
      default:    out_item.status = (found_r == '0) ? ST_NOT_FOUND : ST_OK;
    endcase
  end

endmodule

// File: rtl/max_heap_priority_queue.sv
// channel  | ports                        | handshake
// input    | start, busy, in_item         | accepted when start && !busy
// result   | out_valid, out_item          | one-cycle strobe, cannot be held off
// insert places the key in the new last slot and sifts it up; remove returns the root and sifts the last key down
// find visits up to fill_count nodes, one at a time, through one memory port
// modify is a find followed by a sift of the new key from the found position
// reset clears the fill count; key storage is not cleared
// busy rises after acceptance and falls as the result strobe rises
// the receiver cannot stall the result channel
module max_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mhpq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output mhpq_pkg::out_item_t out_item
);
  import mhpq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  mhpq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_item.action),
    .st     (st),
    .cmd    (cmd),
    .busy   (busy)
  );

  mhpq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
